@@ sv/bcap_pkg.sv @@
package bcap_pkg;

    typedef enum logic [2:0] {
        REG_CONTRAST   = 3'd0,
        REG_BRIGHTNESS = 3'd1,
        REG_GAMMA      = 3'd2,
        REG_RAMP       = 3'd3,
        REG_SEPIA      = 3'd4,
        REG_GRAYSCALE  = 3'd5,
        REG_INVERT     = 3'd6,
        REG_FORMAT     = 3'd7
    } bcap_reg_t;

    typedef enum logic [2:0] {
        FMT_RGB444 = 3'd0,
        FMT_RGB555 = 3'd1,
        FMT_RGB565 = 3'd2,
        FMT_RGB888 = 3'd3
    } bcap_fmt_t;

    typedef struct packed {
        logic signed [7:0] contrast;
        logic signed [7:0] brightness;
        logic [8:0]        gamma;
        logic              ramp;
        logic              sepia;
        logic              gray;
        logic              invert;
        bcap_fmt_t         fmt;
    } bcap_cfg_t;

    localparam logic [7:0] RAMP [32] = '{
        8'h00, 8'h01, 8'h03, 8'h06, 8'h0a, 8'h0f, 8'h15, 8'h1c,
        8'h24, 8'h2d, 8'h37, 8'h42, 8'h4e, 8'h5b, 8'h69, 8'h78,
        8'h88, 8'h90, 8'h98, 8'ha0, 8'ha8, 8'hb0, 8'hb8, 8'hc0,
        8'hc8, 8'hd0, 8'hd8, 8'he0, 8'he8, 8'hf0, 8'hf8, 8'hff
    };

    // q31 value of 2^(2^-j), by repeated integer square roots
    function automatic logic [63:0] bcap_root(input int j);
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        r = 64'h1_0000_0000;
        for (int n = 1; n <= j; n++)
        begin
            v = r << 31;
            res = 64'd0;
            bit_v = 64'h4000_0000_0000_0000;
            for (int s = 0; s < 32; s++)
            begin
                if (v >= res + bit_v)
                begin
                    v = v - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
            r = res;
        end
        return r;
    endfunction

endpackage

@@ sv/bcap_lane.sv @@
module bcap_lane #(
    parameter int GAMMA_FRAC_BITS = 20
) (
    input  logic                clk,
    input  logic                en,
    input  bcap_pkg::bcap_cfg_t cfg,
    input  logic [4:0]          chan,
    output logic [7:0]          level
);

    localparam int F  = GAMMA_FRAC_BITS;
    localparam int LW = F + 4;
    localparam int W  = F + 13;
    localparam logic [LW-1:0] BIG = LW'(8) << F;

    // widen, contrast, brightness
    logic [7:0]         wide;
    logic signed [20:0] slope;
    logic signed [20:0] prod_c;
    logic signed [20:0] n_c;
    logic [7:0]         contr;
    logic signed [9:0]  bsum;
    logic [7:0]         y_next;
    logic [7:0]         y_reg;

    always_comb
    begin
        wide = cfg.ramp ? bcap_pkg::RAMP[chan] : {chan, chan[4:2]};
        slope = 21'sd255 + 21'($signed({cfg.contrast, 1'b0}));
        prod_c = $signed({13'd0, wide}) * slope;
        n_c = prod_c - $signed({{5{cfg.contrast[7]}}, cfg.contrast, 8'd0});
        if (n_c[20])
            contr = 8'd0;
        else if (n_c[19:16] != 4'd0)
            contr = 8'd255;
        else
            contr = n_c[15:8];
        bsum = $signed({2'b00, contr}) + 10'(cfg.brightness);
        if (bsum[9])
            y_next = 8'd0;
        else if (bsum[8])
            y_next = 8'd255;
        else
            y_next = bsum[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    // normalize x+1 into a q31 mantissa
    logic [8:0]  v;
    logic [3:0]  k_next;
    logic [3:0]  k0_reg;
    logic [31:0] m0_reg;

    always_comb
    begin
        v = {1'b0, y_reg} + 9'd1;
        k_next = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (v[i])
                k_next = 4'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k0_reg <= k_next;
            m0_reg <= 32'(v) << (5'd31 - 5'(k_next));
        end
    end

    // log2 fraction, one bit per squaring stage
    logic [31:0]  sq_m_reg [F];
    logic [F-1:0] sq_f_reg [F];
    logic [3:0]   sq_k_reg [F];

    for (genvar g = 0; g < F; g++)
    begin : g_sq
        logic [31:0]  m_in;
        logic [F-1:0] f_in;
        logic [3:0]   k_in;
        logic [63:0]  sq;
        if (g == 0)
        begin : g_first
            assign m_in = m0_reg;
            assign f_in = '0;
            assign k_in = k0_reg;
        end
        else
        begin : g_next
            assign m_in = sq_m_reg[g-1];
            assign f_in = sq_f_reg[g-1];
            assign k_in = sq_k_reg[g-1];
        end
        assign sq = 64'(m_in) * 64'(m_in);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_k_reg[g] <= k_in;
                if (sq[63])
                begin
                    sq_m_reg[g] <= sq[63:32];
                    sq_f_reg[g] <= {f_in[F-2:0], 1'b1};
                end
                else
                begin
                    sq_m_reg[g] <= sq[62:31];
                    sq_f_reg[g] <= {f_in[F-2:0], 1'b0};
                end
            end
        end
    end

    // magnitude of (log - 8) times gamma
    logic [LW-1:0] lg;
    logic [LW-1:0] mag;
    logic [W-1:0]  n_reg;

    assign lg  = {sq_k_reg[F-1], sq_f_reg[F-1]};
    assign mag = BIG - lg;

    always_ff @(posedge clk)
    begin
        if (en)
            n_reg <= W'(mag) * W'(cfg.gamma);
    end

    // division by 100 as a reciprocal product, four partial products then a sum
    localparam int S   = W + 7;
    localparam int H   = (W + 1) / 2;
    localparam int MH  = (W + 2) / 2;
    localparam int NHW = W - H;
    localparam int RHW = W + 1 - MH;
    localparam int P0W = H + MH;
    localparam int P1W = H + RHW;
    localparam int P2W = NHW + MH;
    localparam int P3W = NHW + RHW;
    localparam int PW  = 2 * W + 7;
    localparam logic [63:0]    RECIP64 = ((64'd1 << S) + 64'd99) / 64'd100;
    localparam logic [W:0]     RECIP   = RECIP64[W:0];
    localparam logic [MH-1:0]  R_LO    = RECIP[MH-1:0];
    localparam logic [RHW-1:0] R_HI    = RECIP[W:MH];

    logic [H-1:0]   n_lo;
    logic [NHW-1:0] n_hi;
    logic [P0W-1:0] pll_reg;
    logic [P1W-1:0] plh_reg;
    logic [P2W-1:0] phl_reg;
    logic [P3W-1:0] phh_reg;
    logic [PW-1:0]  sum;
    logic [W-1:0]   q_reg;

    assign n_lo = n_reg[H-1:0];
    assign n_hi = n_reg[W-1:H];
    assign sum  = PW'(pll_reg) + (PW'(plh_reg) << MH) + (PW'(phl_reg) << H)
                + (PW'(phh_reg) << (H + MH));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg <= P0W'(n_lo) * P0W'(R_LO);
            plh_reg <= P1W'(n_lo) * P1W'(R_HI);
            phl_reg <= P2W'(n_hi) * P2W'(R_LO);
            phh_reg <= P3W'(n_hi) * P3W'(R_HI);
            q_reg   <= sum[S +: W];
        end
    end

    // split exponent into integer and fraction
    logic [W-1:0]  q;
    logic [LW-1:0] p;
    logic [2:0]    ex0_kk_reg;
    logic [F-1:0]  ex0_f_reg;
    logic          ex0_zero_reg;
    logic          ex0_sat_reg;

    assign q = q_reg;
    assign p = BIG - LW'(q);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex0_zero_reg <= q > W'(BIG);
            ex0_sat_reg  <= q == '0;
            ex0_kk_reg   <= p[F+2:F];
            ex0_f_reg    <= p[F-1:0];
        end
    end

    // 2^fraction as a product of roots
    logic [31:0]  ex_m_reg    [F];
    logic [F-1:0] ex_f_reg    [F];
    logic [2:0]   ex_kk_reg   [F];
    logic         ex_zero_reg [F];
    logic         ex_sat_reg  [F];

    for (genvar j = 1; j <= F; j++)
    begin : g_exp
        localparam logic [31:0] ROOT = 32'(bcap_pkg::bcap_root(j));
        logic [31:0]  m_in;
        logic [F-1:0] f_in;
        logic [2:0]   kk_in;
        logic         zero_in;
        logic         sat_in;
        logic [63:0]  pr;
        if (j == 1)
        begin : g_first
            assign m_in    = 32'h8000_0000;
            assign f_in    = ex0_f_reg;
            assign kk_in   = ex0_kk_reg;
            assign zero_in = ex0_zero_reg;
            assign sat_in  = ex0_sat_reg;
        end
        else
        begin : g_next
            assign m_in    = ex_m_reg[j-2];
            assign f_in    = ex_f_reg[j-2];
            assign kk_in   = ex_kk_reg[j-2];
            assign zero_in = ex_zero_reg[j-2];
            assign sat_in  = ex_sat_reg[j-2];
        end
        assign pr = 64'(m_in) * 64'(ROOT);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ex_m_reg[j-1]    <= f_in[F-j] ? pr[62:31] : m_in;
                ex_f_reg[j-1]    <= f_in;
                ex_kk_reg[j-1]   <= kk_in;
                ex_zero_reg[j-1] <= zero_in;
                ex_sat_reg[j-1]  <= sat_in;
            end
        end
    end

    logic [38:0] scaled;
    logic [7:0]  level_reg;

    assign scaled = {7'd0, ex_m_reg[F-1]} << ex_kk_reg[F-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ex_zero_reg[F-1])
                level_reg <= 8'd0;
            else if (ex_sat_reg[F-1])
                level_reg <= 8'd255;
            else
                level_reg <= scaled[38:31];
        end
    end

    assign level = level_reg;

endmodule

@@ sv/bcap_merge.sv @@
module bcap_merge (
    input  logic                clk,
    input  logic                en,
    input  bcap_pkg::bcap_cfg_t cfg,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output logic [31:0]         pixel
);

    // first luminance
    logic [21:0] s1_reg;
    logic [7:0]  r1_reg, g1_reg, b1_reg;
    logic [44:0] p1_reg;
    logic [7:0]  r2_reg, g2_reg, b2_reg;
    logic [7:0]  l1;
    logic [11:0] nr_reg;
    logic [17:0] ng_reg, nb_reg;
    logic [7:0]  r3_reg, g3_reg, b3_reg;
    logic [24:0] mr_reg;
    logic [36:0] mg_reg, mb_reg;
    logic [7:0]  r4_reg, g4_reg, b4_reg;

    assign l1 = p1_reg[43:36];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= 22'(red) * 22'd2126 + 22'(green) * 22'd7152 + 22'(blue) * 22'd722;
            r1_reg <= red;
            g1_reg <= green;
            b1_reg <= blue;
            p1_reg <= 45'(s1_reg) * 45'd6871948;
            r2_reg <= r1_reg;
            g2_reg <= g1_reg;
            b2_reg <= b1_reg;
            nr_reg <= 12'(l1) * 12'd13;
            ng_reg <= 18'(l1) * 18'd945;
            nb_reg <= 18'(l1) * 18'd775;
            r3_reg <= r2_reg;
            g3_reg <= g2_reg;
            b3_reg <= b2_reg;
            mr_reg <= 25'(nr_reg) * 25'd6554;
            mg_reg <= 37'(ng_reg) * 37'd268436;
            mb_reg <= 37'(nb_reg) * 37'd268436;
            r4_reg <= r3_reg;
            g4_reg <= g3_reg;
            b4_reg <= b3_reg;
        end
    end

    // sepia select
    logic [8:0] sr, sg, sb;
    logic [7:0] r5_next, g5_next, b5_next;
    logic [7:0] r5_reg, g5_reg, b5_reg;

    always_comb
    begin
        sr = mr_reg[24:16];
        sg = mg_reg[36:28];
        sb = mb_reg[36:28];
        if (cfg.sepia)
        begin
            r5_next = sr[8] ? 8'd255 : sr[7:0];
            g5_next = sg[8] ? 8'd255 : sg[7:0];
            b5_next = sb[8] ? 8'd255 : sb[7:0];
        end
        else
        begin
            r5_next = r4_reg;
            g5_next = g4_reg;
            b5_next = b4_reg;
        end
    end

    // second luminance
    logic [21:0] s2_reg;
    logic [7:0]  r6_reg, g6_reg, b6_reg;
    logic [44:0] p2_reg;
    logic [7:0]  r7_reg, g7_reg, b7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r5_reg <= r5_next;
            g5_reg <= g5_next;
            b5_reg <= b5_next;
            s2_reg <= 22'(r5_reg) * 22'd2126 + 22'(g5_reg) * 22'd7152
                    + 22'(b5_reg) * 22'd722;
            r6_reg <= r5_reg;
            g6_reg <= g5_reg;
            b6_reg <= b5_reg;
            p2_reg <= 45'(s2_reg) * 45'd6871948;
            r7_reg <= r6_reg;
            g7_reg <= g6_reg;
            b7_reg <= b6_reg;
        end
    end

    // grayscale, invert, pack
    logic [7:0]  l2;
    logic [7:0]  ur, ug, ub;
    logic [31:0] pixel_next;
    logic [31:0] pixel_reg;

    always_comb
    begin
        l2 = p2_reg[43:36];
        ur = cfg.gray ? l2 : r7_reg;
        ug = cfg.gray ? l2 : g7_reg;
        ub = cfg.gray ? l2 : b7_reg;
        if (cfg.invert)
        begin
            ur = ~ur;
            ug = ~ug;
            ub = ~ub;
        end
        case (cfg.fmt)
            bcap_pkg::FMT_RGB444: pixel_next = {20'd0, ur[7:4], ug[7:4], ub[7:4]};
            bcap_pkg::FMT_RGB555: pixel_next = {17'd0, ur[7:3], ug[7:3], ub[7:3]};
            bcap_pkg::FMT_RGB565: pixel_next = {16'd0, ur[7:3], ug[7:2], ub[7:3]};
            bcap_pkg::FMT_RGB888: pixel_next = {8'd0, ur, ug, ub};
            default:              pixel_next = 32'hffff_ffff;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pixel_reg <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule

@@ sv/bgr555_color_adjust_and_pack_core.sv @@
// channel  direction  signals                        contents
// s        in         s_tvalid s_tready s_tdata      color_in bgr555 in [14:0]
// m        out        m_tvalid m_tready m_tdata      packed_pixel [31:0]
// cfg      in         cfg_valid cfg_ready cfg_index  register index, cfg_data value
//
// one item per cycle while the last stage is empty or taken; the pipeline depth is
// set by the log2 squaring stages and the exp2 root stages of the three channel lanes with a
// two-stage reciprocal divide by 100 between them, followed by an 8-stage
// luminance/pack merge
// rst_n clears the stage valid bits and loads the register defaults
// the whole pipeline holds while the last stage has an item that is not taken
module bgr555_color_adjust_and_pack_core #(
    parameter int GAMMA_FRAC_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // color_in [14:0], zero [15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // packed_pixel [31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int LAT = 2 * GAMMA_FRAC_BITS + 15;

    bcap_pkg::bcap_cfg_t cfg_reg;
    logic [LAT-1:0]      vld_reg;
    logic                en;
    logic [7:0]          red, green, blue;

    assign cfg_ready = 1'b1;
    assign en        = !vld_reg[LAT-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.contrast   <= 8'sd0;
            cfg_reg.brightness <= 8'sd0;
            cfg_reg.gamma      <= 9'd100;
            cfg_reg.ramp       <= 1'b0;
            cfg_reg.sepia      <= 1'b0;
            cfg_reg.gray       <= 1'b0;
            cfg_reg.invert     <= 1'b0;
            cfg_reg.fmt        <= bcap_pkg::FMT_RGB888;
        end
        else if (cfg_valid)
        begin
            case (bcap_pkg::bcap_reg_t'(cfg_index))
                bcap_pkg::REG_CONTRAST:   cfg_reg.contrast   <= $signed(cfg_data[7:0]);
                bcap_pkg::REG_BRIGHTNESS: cfg_reg.brightness <= $signed(cfg_data[7:0]);
                bcap_pkg::REG_GAMMA:      cfg_reg.gamma      <= cfg_data;
                bcap_pkg::REG_RAMP:       cfg_reg.ramp       <= cfg_data[0];
                bcap_pkg::REG_SEPIA:      cfg_reg.sepia      <= cfg_data[0];
                bcap_pkg::REG_GRAYSCALE:  cfg_reg.gray       <= cfg_data[0];
                bcap_pkg::REG_INVERT:     cfg_reg.invert     <= cfg_data[0];
                bcap_pkg::REG_FORMAT:     cfg_reg.fmt <= bcap_pkg::bcap_fmt_t'(cfg_data[2:0]);
                default:                  cfg_reg.invert     <= cfg_reg.invert;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    bcap_lane #(.GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_lane_r (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .chan  (s_tdata[4:0]),
        .level (red)
    );

    bcap_lane #(.GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_lane_g (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .chan  (s_tdata[9:5]),
        .level (green)
    );

    bcap_lane #(.GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)) u_lane_b (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .chan  (s_tdata[14:10]),
        .level (blue)
    );

    bcap_merge u_merge (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .red   (red),
        .green (green),
        .blue  (blue),
        .pixel (m_tdata)
    );

endmodule
